// ----- rtl/siir_pkg.sv -----
// shared types and constants for the stereo iir filter
// no dependencies; used by stereo_iir_filter_saturating_unit

package siir_pkg;

   // operation carried in the input tuser
   typedef enum logic [1:0] {
      OP_SAMPLE = 2'd0,
      OP_WR_NUM = 2'd1,
      OP_WR_DEN = 2'd2
   } op_type;

   // register indexes (byte address is 4 * index)
   localparam logic [2:0] REG_START_DELAY = 3'd0;
   localparam logic [2:0] REG_NUM_TAPS    = 3'd1;
   localparam logic [2:0] REG_DEN_TAPS    = 3'd2;
   localparam logic [2:0] REG_OUT_GAIN    = 3'd3;
   localparam logic [2:0] REG_LEFT_GAIN   = 3'd4;
   localparam logic [2:0] REG_RIGHT_GAIN  = 3'd5;

   localparam logic signed [31:0] Q24_ONE = 32'sd16777216;

   // largest q24.24 history magnitude
   localparam logic [47:0] HIST_CAP = 48'h7FFF_FFFF_FFFF;

   // clip limits of the gained output, scaled by 2^48
   localparam logic signed [79:0] CLIP_HI = 80'sh7FFF_0000_0000_0000;
   localparam logic signed [79:0] CLIP_LO = -80'sh8000_0000_0000_0000;
   localparam logic signed [15:0] OUT_MAX = 16'sh7FFF;
   localparam logic signed [15:0] OUT_MIN = -16'sh8000;

   // quotient bits produced by the divider
   localparam logic [6:0] DIV_STEPS = 7'd87;

endpackage

// ----- rtl/stereo_iir_filter_saturating_unit.sv -----
// a sample word runs through both channels in turn, each over n+d-1 taps (n, d = taps in use, clamped),
// on one shared 32x25 multiplier (two passes per tap) and a one bit per cycle divider;
// a zero sum or zero a0 skips the divider;
// warm-up sample words skip the taps and the divider, and coefficient writes complete in the idle state.
// throughput: one word at a time; the next is taken once the previous one is finished.
// reset: synchronous, active high; afterwards a clearing pass over all 4*2^ceil(log2(max taps))
// history words (64 at the defaults) zeroes the history memory while no word is accepted.
// depends on siir_pkg

module stereo_iir_filter_saturating_unit #(
   parameter int NUM_TAPS = 16,
   parameter int DEN_TAPS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,   // left_sample, right_sample, coef_index, coef_value, pad
   input  logic [1:0]  req_tuser,   // operation
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // left_out, right_out, clip_count
   output logic [0:0]  rsp_tuser,   // in_warmup
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int MAXT   = (NUM_TAPS > DEN_TAPS) ? NUM_TAPS : DEN_TAPS;
   localparam int IW     = (MAXT > 1) ? $clog2(MAXT) : 1;
   localparam int AW     = IW + 2;
   localparam int MDEPTH = 4 * (2 ** IW);
   localparam int CW     = $clog2(MAXT + 1);
   localparam int TCW    = (CW > 5) ? CW : 5;
   localparam int CN     = (NUM_TAPS < 16) ? NUM_TAPS : 16;
   localparam int CD     = (DEN_TAPS < 16) ? DEN_TAPS : 16;
   localparam int CNW    = (CN > 1) ? $clog2(CN) : 1;
   localparam int CDW    = (CD > 1) ? $clog2(CD) : 1;

   typedef enum logic [12:0] {
      S_CLEAR = 13'b0000000000001,
      S_IDLE  = 13'b0000000000010,
      S_XMUL  = 13'b0000000000100,
      S_XWR   = 13'b0000000001000,
      S_TAPS  = 13'b0000000010000,
      S_DRAIN = 13'b0000000100000,
      S_DIVI  = 13'b0000001000000,
      S_DIV   = 13'b0000010000000,
      S_SC0   = 13'b0000100000000,
      S_SC1   = 13'b0001000000000,
      S_SC2   = 13'b0010000000000,
      S_SAT   = 13'b0100000000000,
      S_FIN   = 13'b1000000000000
   } state_type;

   state_type state_ff, state_in;

   // configuration
   logic [3:0]         start_delay_ff, start_delay_in;
   logic [4:0]         num_taps_ff, num_taps_in;
   logic [4:0]         den_taps_ff, den_taps_in;
   logic signed [31:0] out_gain_ff, out_gain_in;
   logic signed [31:0] left_gain_ff, left_gain_in;
   logic signed [31:0] right_gain_ff, right_gain_in;

   // coefficient tables
   logic signed [31:0] num_coef_ff [CN];
   logic signed [31:0] num_coef_in [CN];
   logic signed [31:0] den_coef_ff [CD];
   logic signed [31:0] den_coef_in [CD];

   // history memory: {channel, output side, index}
   logic [47:0]        hist_mem [MDEPTH];
   logic [47:0]        mem_rd_ff;
   logic               mem_we;
   logic [AW-1:0]      mem_wa, mem_ra;
   logic [47:0]        mem_wd;

   logic [AW-1:0]      clr_ff, clr_in;
   logic [IW-1:0]      xp_ff, xp_in, yp_ff, yp_in, rp_ff, rp_in;
   logic [IW-1:0]      xw, yw;
   logic [3:0]         warm_cnt_ff, warm_cnt_in;
   logic               warm_ff, warm_in;
   logic               ch_ff, ch_in;
   logic signed [15:0] ls_ff, ls_in, rs_ff, rs_in;

   // tap sequencing
   logic               part_ff, part_in;
   logic               ph_ff, ph_in;
   logic [CW-1:0]      tap_ff, tap_in;
   logic [TCW-1:0]     nt_x, dt_x;
   logic [CW-1:0]      nt_c, dt_c;
   logic signed [31:0] coef_q_ff, coef_q_in;
   logic               s1_valid_ff, s1_valid_in, s1_ph_ff, s1_ph_in, s1_sub_ff, s1_sub_in;
   logic               s2_valid_ff, s2_valid_in, s2_ph_ff, s2_ph_in, s2_sub_ff, s2_sub_in;

   // shared multiplier
   logic signed [31:0] mul_a;
   logic signed [24:0] mul_b;
   logic signed [56:0] mul_p;
   logic signed [56:0] prod_ff, prod_in;
   logic signed [63:0] acc_ff, acc_in;
   logic signed [63:0] term;

   // divider
   logic               neg_ff, neg_in, sat_ff, sat_in;
   logic [62:0]        dvd_ff, dvd_in;
   logic [31:0]        dvs_ff, dvs_in;
   logic [31:0]        rem_ff, rem_in;
   logic [47:0]        quo_ff, quo_in;
   logic [6:0]         cnt_ff, cnt_in;
   logic [63:0]        mag;
   logic [31:0]        dmag;
   logic [32:0]        r_sh, r_sub;
   logic               ge;
   logic [47:0]        qv;
   logic signed [47:0] y_ff, y_in;

   // output scaling
   logic signed [79:0] pacc_ff, pacc_in;
   logic signed [79:0] rnd, tq;
   logic               hi, lo;
   logic signed [15:0] sat_val;
   logic signed [15:0] l_out_ff, l_out_in, r_out_ff, r_out_in;
   logic               l_clip_ff, l_clip_in, r_clip_ff, r_clip_in;
   logic [31:0]        clip_total_ff, clip_total_in;
   logic [32:0]        clip_sum;
   logic [31:0]        clip_new;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [63:0]        rsp_data_ff, rsp_data_in;
   logic               rsp_warm_ff, rsp_warm_in;

   logic               cfg_wr, req_acc;
   logic [3:0]         cidx;
   logic signed [31:0] cval;

   assign req_tready = (state_ff == S_IDLE);
   assign req_acc    = req_tvalid && req_tready;
   assign cidx       = req_tdata[35:32];
   assign cval       = $signed(req_tdata[67:36]);
   assign cfg_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_warm_ff;

   always_comb begin
      case (csr_paddr[4:2])
         siir_pkg::REG_START_DELAY: csr_prdata = 32'(start_delay_ff);
         siir_pkg::REG_NUM_TAPS:    csr_prdata = 32'(num_taps_ff);
         siir_pkg::REG_DEN_TAPS:    csr_prdata = 32'(den_taps_ff);
         siir_pkg::REG_OUT_GAIN:    csr_prdata = out_gain_ff;
         siir_pkg::REG_LEFT_GAIN:   csr_prdata = left_gain_ff;
         siir_pkg::REG_RIGHT_GAIN:  csr_prdata = right_gain_ff;
         default:                   csr_prdata = 32'd0;
      endcase
   end

   // tap counts: zero counts as one, large counts stop at NUM_TAPS or DEN_TAPS
   always_comb begin
      nt_x = TCW'(num_taps_ff);
      dt_x = TCW'(den_taps_ff);
      if (nt_x == '0) begin
         nt_x = TCW'(1);
      end else if (nt_x > TCW'(NUM_TAPS)) begin
         nt_x = TCW'(NUM_TAPS);
      end
      if (dt_x == '0) begin
         dt_x = TCW'(1);
      end else if (dt_x > TCW'(DEN_TAPS)) begin
         dt_x = TCW'(DEN_TAPS);
      end
      nt_c = nt_x[CW-1:0];
      dt_c = dt_x[CW-1:0];
   end

   assign xw = (xp_ff == IW'(NUM_TAPS - 1)) ? '0 : xp_ff + IW'(1);
   assign yw = (yp_ff == IW'(DEN_TAPS - 1)) ? '0 : yp_ff + IW'(1);

   // multiplier operands: tap pipeline first, else the sequencer's own use
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      if (s1_valid_ff) begin
         mul_a = coef_q_ff;
         mul_b = s1_ph_ff ? $signed({mem_rd_ff[47], mem_rd_ff[47:24]})
                          : $signed({1'b0, mem_rd_ff[23:0]});
      end else begin
         case (state_ff)
            S_XMUL: begin
               mul_a = ch_ff ? right_gain_ff : left_gain_ff;
               mul_b = 25'(ch_ff ? rs_ff : ls_ff);
            end
            S_SC0: begin
               mul_a = out_gain_ff;
               mul_b = $signed({1'b0, y_ff[23:0]});
            end
            S_SC1: begin
               mul_a = out_gain_ff;
               mul_b = $signed({y_ff[47], y_ff[47:24]});
            end
            default: begin
               mul_a = '0;
               mul_b = '0;
            end
         endcase
      end
   end

   assign mul_p = mul_a * mul_b;
   assign term  = s2_ph_ff ? 64'(prod_ff) : 64'(prod_ff >>> 24);

   // divider datapath, one quotient bit per cycle
   assign mag   = acc_ff[63] ? 64'(-acc_ff) : 64'(acc_ff);
   assign dmag  = den_coef_ff[0][31] ? 32'(-den_coef_ff[0]) : 32'(den_coef_ff[0]);
   assign r_sh  = {1'b0, rem_ff} << 1 | 33'(dvd_ff[62]);
   assign r_sub = r_sh - {1'b0, dvs_ff};
   assign ge    = (r_sh >= {1'b0, dvs_ff});

   // output scaling: truncate toward zero, clip against the real value
   assign hi      = (pacc_ff > siir_pkg::CLIP_HI);
   assign lo      = (pacc_ff < siir_pkg::CLIP_LO);
   assign rnd     = pacc_ff + (pacc_ff[79] ? 80'sh0000_FFFF_FFFF_FFFF : 80'sd0);
   assign tq      = rnd >>> 48;
   assign sat_val = hi ? siir_pkg::OUT_MAX : (lo ? siir_pkg::OUT_MIN : tq[15:0]);

   assign clip_sum = {1'b0, clip_total_ff} + 33'(l_clip_ff) + 33'(r_clip_ff);
   assign clip_new = clip_sum[32] ? 32'hFFFF_FFFF : clip_sum[31:0];

   always_comb begin
      state_in       = state_ff;
      start_delay_in = start_delay_ff;
      num_taps_in    = num_taps_ff;
      den_taps_in    = den_taps_ff;
      out_gain_in    = out_gain_ff;
      left_gain_in   = left_gain_ff;
      right_gain_in  = right_gain_ff;
      num_coef_in    = num_coef_ff;
      den_coef_in    = den_coef_ff;
      clr_in         = clr_ff;
      xp_in          = xp_ff;
      yp_in          = yp_ff;
      rp_in          = rp_ff;
      warm_cnt_in    = warm_cnt_ff;
      warm_in        = warm_ff;
      ch_in          = ch_ff;
      ls_in          = ls_ff;
      rs_in          = rs_ff;
      part_in        = part_ff;
      ph_in          = ph_ff;
      tap_in         = tap_ff;
      coef_q_in      = coef_q_ff;
      s1_valid_in    = 1'b0;
      s1_ph_in       = ph_ff;
      s1_sub_in      = part_ff;
      s2_valid_in    = s1_valid_ff;
      s2_ph_in       = s1_ph_ff;
      s2_sub_in      = s1_sub_ff;
      prod_in        = mul_p;
      acc_in         = acc_ff;
      neg_in         = neg_ff;
      sat_in         = sat_ff;
      dvd_in         = dvd_ff;
      dvs_in         = dvs_ff;
      rem_in         = rem_ff;
      quo_in         = quo_ff;
      cnt_in         = cnt_ff;
      qv             = '0;
      y_in           = y_ff;
      pacc_in        = pacc_ff;
      l_out_in       = l_out_ff;
      r_out_in       = r_out_ff;
      l_clip_in      = l_clip_ff;
      r_clip_in      = r_clip_ff;
      clip_total_in  = clip_total_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_data_in    = rsp_data_ff;
      rsp_warm_in    = rsp_warm_ff;
      mem_we         = 1'b0;
      mem_wa         = {ch_ff, 1'b0, xw};
      mem_wd         = prod_ff[47:0];
      mem_ra         = {ch_ff, part_ff, rp_ff};

      if (cfg_wr) begin
         case (csr_paddr[4:2])
            siir_pkg::REG_START_DELAY: start_delay_in = csr_pwdata[3:0];
            siir_pkg::REG_NUM_TAPS:    num_taps_in    = csr_pwdata[4:0];
            siir_pkg::REG_DEN_TAPS:    den_taps_in    = csr_pwdata[4:0];
            siir_pkg::REG_OUT_GAIN:    out_gain_in    = $signed(csr_pwdata);
            siir_pkg::REG_LEFT_GAIN:   left_gain_in   = $signed(csr_pwdata);
            siir_pkg::REG_RIGHT_GAIN:  right_gain_in  = $signed(csr_pwdata);
            default: ;
         endcase
      end

      if (s2_valid_ff) begin
         acc_in = s2_sub_ff ? acc_ff - term : acc_ff + term;
      end

      case (state_ff)
         S_CLEAR: begin
            mem_we = 1'b1;
            mem_wa = clr_ff;
            mem_wd = '0;
            clr_in = clr_ff + AW'(1);
            if (clr_ff == '1) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_acc) begin
               case (siir_pkg::op_type'(req_tuser))
                  siir_pkg::OP_SAMPLE: begin
                     ls_in    = $signed(req_tdata[15:0]);
                     rs_in    = $signed(req_tdata[31:16]);
                     warm_in  = (warm_cnt_ff < start_delay_ff);
                     if (warm_cnt_ff < start_delay_ff) begin
                        warm_cnt_in = warm_cnt_ff + 4'd1;
                     end
                     ch_in    = 1'b0;
                     state_in = S_XMUL;
                  end
                  siir_pkg::OP_WR_NUM: begin
                     if ({1'b0, cidx} < 5'(CN)) begin
                        num_coef_in[cidx[CNW-1:0]] = cval;
                     end
                  end
                  siir_pkg::OP_WR_DEN: begin
                     if ({1'b0, cidx} < 5'(CD)) begin
                        den_coef_in[cidx[CDW-1:0]] = cval;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_XMUL: begin
            state_in = S_XWR;
         end
         S_XWR: begin
            // newest input history word goes in ahead of the taps
            mem_we = 1'b1;
            mem_wa = {ch_ff, 1'b0, xw};
            mem_wd = prod_ff[47:0];
            if (warm_ff) begin
               if (ch_ff) begin
                  r_out_in  = '0;
                  r_clip_in = 1'b0;
                  state_in  = S_FIN;
               end else begin
                  l_out_in  = '0;
                  l_clip_in = 1'b0;
                  ch_in     = 1'b1;
                  state_in  = S_XMUL;
               end
            end else begin
               part_in  = 1'b0;
               tap_in   = '0;
               ph_in    = 1'b0;
               rp_in    = xw;
               acc_in   = '0;
               state_in = S_TAPS;
            end
         end
         S_TAPS: begin
            mem_ra      = {ch_ff, part_ff, rp_ff};
            s1_valid_in = 1'b1;
            if (part_ff) begin
               coef_q_in = (tap_ff < CW'(CD)) ? den_coef_ff[tap_ff[CDW-1:0]] : '0;
            end else begin
               coef_q_in = (tap_ff < CW'(CN)) ? num_coef_ff[tap_ff[CNW-1:0]] : '0;
            end
            if (!ph_ff) begin
               ph_in = 1'b1;
            end else begin
               ph_in = 1'b0;
               if (!part_ff) begin
                  if ((tap_ff + CW'(1)) == nt_c) begin
                     if (dt_c == CW'(1)) begin
                        state_in = S_DRAIN;
                     end else begin
                        part_in = 1'b1;
                        tap_in  = CW'(1);
                        rp_in   = yp_ff;
                     end
                  end else begin
                     tap_in = tap_ff + CW'(1);
                     rp_in  = (rp_ff == '0) ? IW'(NUM_TAPS - 1) : rp_ff - IW'(1);
                  end
               end else begin
                  if ((tap_ff + CW'(1)) == dt_c) begin
                     state_in = S_DRAIN;
                  end else begin
                     tap_in = tap_ff + CW'(1);
                     rp_in  = (rp_ff == '0) ? IW'(DEN_TAPS - 1) : rp_ff - IW'(1);
                  end
               end
            end
         end
         S_DRAIN: begin
            // last product is summed on this edge once stage one is empty
            if (!s1_valid_ff) begin
               state_in = S_DIVI;
            end
         end
         S_DIVI: begin
            neg_in = acc_ff[63] ^ den_coef_ff[0][31];
            dvd_in = mag[62:0];
            dvs_in = dmag;
            rem_in = '0;
            quo_in = '0;
            sat_in = 1'b0;
            cnt_in = siir_pkg::DIV_STEPS - 7'd1;
            if (mag == '0) begin
               y_in     = '0;
               state_in = S_SC0;
            end else if (dmag == '0) begin
               // zero a0 saturates with the sign of the sum
               y_in     = acc_ff[63] ? -$signed(siir_pkg::HIST_CAP)
                                     : $signed(siir_pkg::HIST_CAP);
               state_in = S_SC0;
            end else begin
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            rem_in = ge ? r_sub[31:0] : r_sh[31:0];
            dvd_in = {dvd_ff[61:0], 1'b0};
            quo_in = {quo_ff[46:0], ge};
            sat_in = sat_ff | quo_ff[47] | quo_ff[46];
            cnt_in = cnt_ff - 7'd1;
            if (cnt_ff == '0) begin
               qv       = sat_in ? siir_pkg::HIST_CAP : quo_in;
               y_in     = neg_ff ? -$signed(qv) : $signed(qv);
               state_in = S_SC0;
            end
         end
         S_SC0: begin
            mem_we   = 1'b1;
            mem_wa   = {ch_ff, 1'b1, yw};
            mem_wd   = y_ff;
            state_in = S_SC1;
         end
         S_SC1: begin
            pacc_in  = 80'(prod_ff);
            state_in = S_SC2;
         end
         S_SC2: begin
            pacc_in  = pacc_ff + (80'(prod_ff) <<< 24);
            state_in = S_SAT;
         end
         S_SAT: begin
            if (ch_ff) begin
               r_out_in  = sat_val;
               r_clip_in = hi | lo;
               state_in  = S_FIN;
            end else begin
               l_out_in  = sat_val;
               l_clip_in = hi | lo;
               ch_in     = 1'b1;
               state_in  = S_XMUL;
            end
         end
         S_FIN: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_data_in   = {clip_new, r_out_ff, l_out_ff};
               rsp_warm_in   = warm_ff;
               clip_total_in = clip_new;
               xp_in         = xw;
               if (!warm_ff) begin
                  yp_in = yw;
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         hist_mem[mem_wa] <= mem_wd;
      end
      mem_rd_ff <= hist_mem[mem_ra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_CLEAR;
         start_delay_ff <= '0;
         num_taps_ff    <= 5'd1;
         den_taps_ff    <= 5'd1;
         out_gain_ff    <= siir_pkg::Q24_ONE;
         left_gain_ff   <= siir_pkg::Q24_ONE;
         right_gain_ff  <= siir_pkg::Q24_ONE;
         for (int i = 0; i < CN; i++) begin
            num_coef_ff[i] <= (i == 0) ? siir_pkg::Q24_ONE : 32'sd0;
         end
         for (int i = 0; i < CD; i++) begin
            den_coef_ff[i] <= (i == 0) ? siir_pkg::Q24_ONE : 32'sd0;
         end
         clr_ff        <= '0;
         xp_ff         <= '0;
         yp_ff         <= '0;
         warm_cnt_ff   <= '0;
         s1_valid_ff   <= 1'b0;
         s2_valid_ff   <= 1'b0;
         clip_total_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff       <= state_in;
         start_delay_ff <= start_delay_in;
         num_taps_ff    <= num_taps_in;
         den_taps_ff    <= den_taps_in;
         out_gain_ff    <= out_gain_in;
         left_gain_ff   <= left_gain_in;
         right_gain_ff  <= right_gain_in;
         num_coef_ff    <= num_coef_in;
         den_coef_ff    <= den_coef_in;
         clr_ff         <= clr_in;
         xp_ff          <= xp_in;
         yp_ff          <= yp_in;
         warm_cnt_ff    <= warm_cnt_in;
         s1_valid_ff    <= s1_valid_in;
         s2_valid_ff    <= s2_valid_in;
         clip_total_ff  <= clip_total_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rp_ff       <= rp_in;
      warm_ff     <= warm_in;
      ch_ff       <= ch_in;
      ls_ff       <= ls_in;
      rs_ff       <= rs_in;
      part_ff     <= part_in;
      ph_ff       <= ph_in;
      tap_ff      <= tap_in;
      coef_q_ff   <= coef_q_in;
      s1_ph_ff    <= s1_ph_in;
      s1_sub_ff   <= s1_sub_in;
      s2_ph_ff    <= s2_ph_in;
      s2_sub_ff   <= s2_sub_in;
      prod_ff     <= prod_in;
      acc_ff      <= acc_in;
      neg_ff      <= neg_in;
      sat_ff      <= sat_in;
      dvd_ff      <= dvd_in;
      dvs_ff      <= dvs_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      cnt_ff      <= cnt_in;
      y_ff        <= y_in;
      pacc_ff     <= pacc_in;
      l_out_ff    <= l_out_in;
      r_out_ff    <= r_out_in;
      l_clip_ff   <= l_clip_in;
      r_clip_ff   <= r_clip_in;
      rsp_data_ff <= rsp_data_in;
      rsp_warm_ff <= rsp_warm_in;
   end

endmodule
